[hdl/frasm_pkg.sv]
// Shared types and constants for the fragment reassembler.
package frasm_pkg;

	typedef enum logic [1:0] {
		CMD_FRAG  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	localparam int          LEN_W         = 15;
	localparam logic [14:0] COUNT_MAX     = 15'h7FFF;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
	localparam int          ADDR_FULL_W   = 21;
	localparam int          OQ_DEPTH      = 3;
	localparam int          OQ_PW         = 2;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  frag_number;
		logic [7:0]  byte_offset;
		logic [7:0]  data_byte;
		logic        byte_valid;
		logic        first_of_fragment;
		logic        end_flag;
		logic        broadcast_class;
		logic [31:0] message_id;
		logic [47:0] source_addr;
		logic [47:0] dest_addr;
	} req_t;

	typedef struct packed {
		logic              duplicate;
		logic              range_error;
		logic              complete;
		logic              timed_out;
		logic [LEN_W-1:0]  msg_length;
		logic [7:0]        read_data;
		logic [31:0]       msg_id_out;
		logic [47:0]       source_out;
		logic [47:0]       dest_out;
	} result_t;

endpackage

[hdl/frasm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module frasm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/frasm_ctrl.sv]
// Reassembly state update, fragment bitmap and message buffer access.
module frasm_ctrl #(
	parameter int FRAG_SIZE     = 256,
	parameter int MAX_FRAGMENTS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	input  logic                acc,
	input  frasm_pkg::req_t     req,
	output logic                res_valid,
	output frasm_pkg::result_t  res
);

	localparam int DEPTH = MAX_FRAGMENTS * FRAG_SIZE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW    = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int CW    = $clog2(MAX_FRAGMENTS + 1);

	logic [31:0]                    timeout_q;
	logic [MAX_FRAGMENTS-1:0]       map_q, map_n;
	logic [CW-1:0]                  count_q, count_n;
	logic [FW-1:0]                  end_q, end_n;
	logic                           known_q, known_n;
	logic                           disc_q, disc_n;
	logic [frasm_pkg::LEN_W-1:0]    bytes_q, bytes_n;
	logic [31:0]                    left_q, left_n, left_dec;
	logic                           armed_q, armed_n;
	logic [31:0]                    id_q, id_n;
	logic [47:0]                    src_q, src_n;
	logic [47:0]                    dst_q, dst_n;

	logic                           in_range, offs_ok;
	logic [FW-1:0]                  fi;
	logic [frasm_pkg::ADDR_FULL_W-1:0] addr_full;
	logic [AW-1:0]                  addr;
	logic                           dup, rerr, tout, wr_en, rd_en;
	logic [7:0]                     ram_q;

	logic                           valid_s1, dup_s1, rerr_s1, cmpl_s1, tout_s1, rd_s1;
	logic [frasm_pkg::LEN_W-1:0]    len_s1;
	logic [31:0]                    id_s1;
	logic [47:0]                    src_s1, dst_s1;

	assign in_range  = 9'(req.frag_number) < 9'(MAX_FRAGMENTS);
	assign offs_ok   = 13'(req.byte_offset) < 13'(FRAG_SIZE);
	assign fi        = req.frag_number[FW-1:0];
	assign addr_full = frasm_pkg::ADDR_FULL_W'(req.frag_number)
		* frasm_pkg::ADDR_FULL_W'(FRAG_SIZE)
		+ frasm_pkg::ADDR_FULL_W'(req.byte_offset);
	assign addr      = addr_full[AW-1:0];
	assign left_dec  = (left_q != 32'd0) ? left_q - 32'd1 : left_q;

	always_comb begin
		map_n   = map_q;
		count_n = count_q;
		end_n   = end_q;
		known_n = known_q;
		disc_n  = disc_q;
		bytes_n = bytes_q;
		left_n  = left_q;
		armed_n = armed_q;
		id_n    = id_q;
		src_n   = src_q;
		dst_n   = dst_q;
		dup     = 1'b0;
		rerr    = 1'b0;
		tout    = 1'b0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		case (req.cmd)
			frasm_pkg::CMD_FRAG: begin
				if (req.first_of_fragment) begin
					if (req.broadcast_class) begin
						armed_n = 1'b0;
					end else begin
						armed_n = 1'b1;
						left_n  = timeout_q;
					end
				end
				if (!in_range) begin
					rerr = 1'b1;
					if (req.first_of_fragment) begin
						disc_n = 1'b1;
					end
				end else begin
					if (req.first_of_fragment) begin
						if (map_q[fi]) begin
							disc_n = 1'b1;
						end else begin
							disc_n    = 1'b0;
							map_n[fi] = 1'b1;
							count_n   = count_q + CW'(1);
							id_n      = req.message_id;
							src_n     = req.source_addr;
							dst_n     = req.dest_addr;
							if (req.end_flag) begin
								end_n   = fi;
								known_n = 1'b1;
							end
						end
					end
					if (disc_n) begin
						dup = 1'b1;
					end else if (req.byte_valid && offs_ok) begin
						wr_en = 1'b1;
						if (bytes_q != frasm_pkg::COUNT_MAX) begin
							bytes_n = bytes_q + frasm_pkg::LEN_W'(1);
						end
					end
				end
			end
			frasm_pkg::CMD_TICK: begin
				if (armed_q) begin
					left_n = left_dec;
					if (left_dec == 32'd0) begin
						tout    = 1'b1;
						armed_n = 1'b0;
					end
				end
			end
			frasm_pkg::CMD_READ: begin
				if (in_range && offs_ok) begin
					rd_en = 1'b1;
				end else begin
					rerr = 1'b1;
				end
			end
			frasm_pkg::CMD_CLEAR: begin
				map_n   = '0;
				count_n = '0;
				end_n   = '0;
				known_n = 1'b0;
				disc_n  = 1'b0;
				bytes_n = '0;
				left_n  = '0;
				armed_n = 1'b0;
				id_n    = '0;
				src_n   = '0;
				dst_n   = '0;
			end
			default: begin
				dup = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= frasm_pkg::TIMEOUT_RESET;
			map_q     <= '0;
			count_q   <= '0;
			end_q     <= '0;
			known_q   <= 1'b0;
			disc_q    <= 1'b0;
			bytes_q   <= '0;
			left_q    <= '0;
			armed_q   <= 1'b0;
			id_q      <= '0;
			src_q     <= '0;
			dst_q     <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			valid_s1 <= acc;
			if (acc) begin
				map_q   <= map_n;
				count_q <= count_n;
				end_q   <= end_n;
				known_q <= known_n;
				disc_q  <= disc_n;
				bytes_q <= bytes_n;
				left_q  <= left_n;
				armed_q <= armed_n;
				id_q    <= id_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dup_s1  <= dup;
			rerr_s1 <= rerr;
			cmpl_s1 <= known_n && (count_n == CW'(end_n) + CW'(1));
			tout_s1 <= tout;
			rd_s1   <= rd_en;
			len_s1  <= bytes_n;
			id_s1   <= id_n;
			src_s1  <= src_n;
			dst_s1  <= dst_n;
		end
	end

	frasm_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (acc && wr_en),
		.waddr(addr),
		.wdata(req.data_byte),
		.re   (acc && rd_en),
		.raddr(addr),
		.rdata(ram_q)
	);

	assign res_valid       = valid_s1;
	assign res.duplicate   = dup_s1;
	assign res.range_error = rerr_s1;
	assign res.complete    = cmpl_s1;
	assign res.timed_out   = tout_s1;
	assign res.msg_length  = len_s1;
	assign res.read_data   = rd_s1 ? ram_q : 8'd0;
	assign res.msg_id_out  = id_s1;
	assign res.source_out  = src_s1;
	assign res.dest_out    = dst_s1;

endmodule

[hdl/frasm_outq.sv]
// Three-entry result queue that decouples output stall from input stall.
module frasm_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  frasm_pkg::result_t  push_data,
	output logic                full_soon,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output frasm_pkg::result_t  rsp_data
);

	frasm_pkg::result_t             ent_q [frasm_pkg::OQ_DEPTH];
	logic [frasm_pkg::OQ_PW-1:0]    wr_q, rd_q, occ_q;
	logic                           pop;

	assign rsp_valid = occ_q != '0;
	assign rsp_data  = ent_q[rd_q];
	assign pop       = rsp_valid && !rsp_stall;
	assign full_soon = (3'(occ_q) + 3'(push)) >= 3'(frasm_pkg::OQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			occ_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == frasm_pkg::OQ_PW'(frasm_pkg::OQ_DEPTH - 1)) ? '0 :
					wr_q + frasm_pkg::OQ_PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == frasm_pkg::OQ_PW'(frasm_pkg::OQ_DEPTH - 1)) ? '0 :
					rd_q + frasm_pkg::OQ_PW'(1);
			end
			if (push && !pop) begin
				occ_q <= occ_q + frasm_pkg::OQ_PW'(1);
			end else if (pop && !push) begin
				occ_q <= occ_q - frasm_pkg::OQ_PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

[hdl/fragment_reassembler.sv]
// Top level of the fragment reassembler.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  request | req_valid | req_stall | cmd, frag_number ... dest_addr
//  result  | rsp_valid | rsp_stall | duplicate, range_error ... dest_out
//  config  | cfg_we    | -         | cfg_wdata (timeout_ticks)
//
// One request per cycle while req_stall is low; its result goes through the result stage
// and the output queue (state update and buffer write at accept, buffer read data registered).
// Reset clears all control state and sets the timeout to 1000 ticks; buffer
// contents are undefined until written.
// req_stall is high while the three-entry output queue and the result stage hold
// three results; rsp_stall reaches req_stall only through registers.
module fragment_reassembler #(
	parameter int FRAG_SIZE     = 256,
	parameter int MAX_FRAGMENTS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         req_valid,
	output logic         req_stall,
	input  logic [1:0]   cmd,
	input  logic [7:0]   frag_number,
	input  logic [7:0]   byte_offset,
	input  logic [7:0]   data_byte,
	input  logic         byte_valid,
	input  logic         first_of_fragment,
	input  logic         last_of_fragment,
	input  logic         end_flag,
	input  logic         broadcast_class,
	input  logic [31:0]  message_id,
	input  logic [47:0]  source_addr,
	input  logic [47:0]  dest_addr,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output logic         duplicate,
	output logic         range_error,
	output logic         complete,
	output logic         timed_out,
	output logic [14:0]  msg_length,
	output logic [7:0]   read_data,
	output logic [31:0]  msg_id_out,
	output logic [47:0]  source_out,
	output logic [47:0]  dest_out
);

	frasm_pkg::req_t     req;
	frasm_pkg::result_t  res, out;
	logic                res_valid, acc, full_soon, unused_last;

	// fragment end is implied by the next first item
	assign unused_last = last_of_fragment;

	assign req.cmd               = frasm_pkg::cmd_t'(cmd);
	assign req.frag_number       = frag_number;
	assign req.byte_offset       = byte_offset;
	assign req.data_byte         = data_byte;
	assign req.byte_valid        = byte_valid;
	assign req.first_of_fragment = first_of_fragment;
	assign req.end_flag          = end_flag;
	assign req.broadcast_class   = broadcast_class;
	assign req.message_id        = message_id;
	assign req.source_addr       = source_addr;
	assign req.dest_addr         = dest_addr;

	assign req_stall = full_soon;
	assign acc       = req_valid && !full_soon;

	frasm_ctrl #(
		.FRAG_SIZE    (FRAG_SIZE),
		.MAX_FRAGMENTS(MAX_FRAGMENTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.acc      (acc),
		.req      (req),
		.res_valid(res_valid),
		.res      (res)
	);

	frasm_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.full_soon(full_soon),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (out)
	);

	assign duplicate   = out.duplicate;
	assign range_error = out.range_error;
	assign complete    = out.complete;
	assign timed_out   = out.timed_out;
	assign msg_length  = out.msg_length;
	assign read_data   = out.read_data;
	assign msg_id_out  = out.msg_id_out;
	assign source_out  = out.source_out;
	assign dest_out    = out.dest_out;

endmodule

[test/frasm_checker.sv]
// Checker for the fragment reassembler: watches both channels, predicts each result and compares.
module frasm_checker #(
	parameter int FRAG_SIZE     = 256,
	parameter int MAX_FRAGMENTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  logic             req_valid,
	input  logic             req_stall,
	input  frasm_pkg::req_t  req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  logic             duplicate,
	input  logic             range_error,
	input  logic             complete,
	input  logic             timed_out,
	input  logic [14:0]      msg_length,
	input  logic [7:0]       read_data,
	input  logic [31:0]      msg_id_out,
	input  logic [47:0]      source_out,
	input  logic [47:0]      dest_out,
	output int               fail_count,
	output int               pending
);

	logic [7:0]          buffer_mem [MAX_FRAGMENTS*FRAG_SIZE];
	bit                  frag_seen [MAX_FRAGMENTS];
	int                  frag_total;
	int                  last_frag;
	logic                last_frag_known;
	logic                dropping;
	logic [14:0]         bytes_taken;
	logic [31:0]         ticks_left;
	logic                timer_on;
	logic [31:0]         hdr_id;
	logic [47:0]         hdr_src;
	logic [47:0]         hdr_dst;
	logic [31:0]         timeout_cfg;
	frasm_pkg::result_t  expected_q [$];

	function automatic void clear_message();
		foreach (frag_seen[i])
			frag_seen[i] = 1'b0;
		frag_total      = 0;
		last_frag       = 0;
		last_frag_known = 1'b0;
		dropping        = 1'b0;
		bytes_taken     = '0;
		ticks_left      = '0;
		timer_on        = 1'b0;
		hdr_id          = '0;
		hdr_src         = '0;
		hdr_dst         = '0;
	endfunction

	function automatic frasm_pkg::result_t reassemble(input frasm_pkg::req_t r);
		frasm_pkg::result_t res;
		int                 addr;
		res  = '0;
		addr = int'(r.frag_number) * FRAG_SIZE + int'(r.byte_offset);
		case (r.cmd)
			frasm_pkg::CMD_FRAG: begin
				if (r.first_of_fragment) begin
					timer_on = !r.broadcast_class;
					if (!r.broadcast_class)
						ticks_left = timeout_cfg;
				end
				if (r.frag_number >= MAX_FRAGMENTS) begin
					res.range_error = 1'b1;
					if (r.first_of_fragment)
						dropping = 1'b1;
				end else begin
					if (r.first_of_fragment) begin
						if (frag_seen[r.frag_number]) begin
							dropping = 1'b1;
						end else begin
							dropping = 1'b0;
							frag_seen[r.frag_number] = 1'b1;
							frag_total++;
							hdr_id  = r.message_id;
							hdr_src = r.source_addr;
							hdr_dst = r.dest_addr;
							if (r.end_flag) begin
								last_frag       = int'(r.frag_number);
								last_frag_known = 1'b1;
							end
						end
					end
					if (dropping) begin
						res.duplicate = 1'b1;
					end else if (r.byte_valid && r.byte_offset < FRAG_SIZE) begin
						buffer_mem[addr] = r.data_byte;
						if (bytes_taken != frasm_pkg::COUNT_MAX)
							bytes_taken++;
					end
				end
			end
			frasm_pkg::CMD_TICK: begin
				if (timer_on) begin
					if (ticks_left != 0)
						ticks_left--;
					if (ticks_left == 0) begin
						res.timed_out = 1'b1;
						timer_on      = 1'b0;
					end
				end
			end
			frasm_pkg::CMD_READ: begin
				if (r.frag_number < MAX_FRAGMENTS && r.byte_offset < FRAG_SIZE)
					res.read_data = buffer_mem[addr];
				else
					res.range_error = 1'b1;
			end
			default: clear_message();
		endcase
		res.complete   = last_frag_known && (frag_total == last_frag + 1);
		res.msg_length = bytes_taken;
		res.msg_id_out = hdr_id;
		res.source_out = hdr_src;
		res.dest_out   = hdr_dst;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
		fail_count++;
	endtask

	task automatic check_result(input frasm_pkg::result_t want);
		if (duplicate !== want.duplicate)
			report_mismatch("duplicate", duplicate, want.duplicate);
		if (range_error !== want.range_error)
			report_mismatch("range_error", range_error, want.range_error);
		if (complete !== want.complete)
			report_mismatch("complete", complete, want.complete);
		if (timed_out !== want.timed_out)
			report_mismatch("timed_out", timed_out, want.timed_out);
		if (msg_length !== want.msg_length)
			report_mismatch("msg_length", msg_length, want.msg_length);
		if (read_data !== want.read_data)
			report_mismatch("read_data", read_data, want.read_data);
		if (msg_id_out !== want.msg_id_out)
			report_mismatch("msg_id_out", msg_id_out, want.msg_id_out);
		if (source_out !== want.source_out)
			report_mismatch("source_out", source_out, want.source_out);
		if (dest_out !== want.dest_out)
			report_mismatch("dest_out", dest_out, want.dest_out);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_message();
			timeout_cfg = frasm_pkg::TIMEOUT_RESET;
			expected_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0)
					report_mismatch("result with nothing expected", 1, 0);
				else
					check_result(expected_q.pop_front());
			end
			if (req_valid && !req_stall)
				expected_q.push_back(reassemble(req));
			if (cfg_we)
				timeout_cfg = cfg_wdata;
			pending <= expected_q.size();
		end
	end

endmodule

[test/tb_top.sv]
// Testbench top for the fragment reassembler: clock, reset, stimulus and verdict.
module tb_top;

	localparam int FRAG_SIZE     = 256;
	localparam int MAX_FRAGMENTS = 64;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int LONG_STREAM   = 40;
	localparam int DRAIN_CYCLES  = 6;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we;
	logic [31:0]      cfg_wdata;
	logic             req_valid;
	logic             req_stall;
	frasm_pkg::req_t  req;
	logic             frag_last;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	logic             duplicate;
	logic             range_error;
	logic             complete;
	logic             timed_out;
	logic [14:0]      msg_length;
	logic [7:0]       read_data;
	logic [31:0]      msg_id_out;
	logic [47:0]      source_out;
	logic [47:0]      dest_out;
	int               fail_count;
	int               pending;

	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          cycle_count = 0;
	int          accepted_items = 0;
	logic [31:0] cur_id;
	logic [47:0] cur_src;
	logic [47:0] cur_dst;
	bit          frag_sent [MAX_FRAGMENTS];
	bit          skipping;
	bit          byte_written [MAX_FRAGMENTS*FRAG_SIZE];
	int          written_list [$];

	fragment_reassembler #(
		.FRAG_SIZE(FRAG_SIZE),
		.MAX_FRAGMENTS(MAX_FRAGMENTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(req.cmd),
		.frag_number(req.frag_number),
		.byte_offset(req.byte_offset),
		.data_byte(req.data_byte),
		.byte_valid(req.byte_valid),
		.first_of_fragment(req.first_of_fragment),
		.last_of_fragment(frag_last),
		.end_flag(req.end_flag),
		.broadcast_class(req.broadcast_class),
		.message_id(req.message_id),
		.source_addr(req.source_addr),
		.dest_addr(req.dest_addr),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.duplicate(duplicate),
		.range_error(range_error),
		.complete(complete),
		.timed_out(timed_out),
		.msg_length(msg_length),
		.read_data(read_data),
		.msg_id_out(msg_id_out),
		.source_out(source_out),
		.dest_out(dest_out)
	);

	frasm_checker #(
		.FRAG_SIZE(FRAG_SIZE),
		.MAX_FRAGMENTS(MAX_FRAGMENTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.duplicate(duplicate),
		.range_error(range_error),
		.complete(complete),
		.timed_out(timed_out),
		.msg_length(msg_length),
		.read_data(read_data),
		.msg_id_out(msg_id_out),
		.source_out(source_out),
		.dest_out(dest_out),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(negedge clk)
		rsp_stall <= ($urandom_range(99) < rx_stall_pct);

	function automatic frasm_pkg::req_t random_item();
		frasm_pkg::req_t r;
		r.cmd               = frasm_pkg::cmd_t'(2'($urandom_range(3)));
		r.frag_number       = 8'($urandom_range(255));
		r.byte_offset       = 8'($urandom_range(255));
		r.data_byte         = 8'($urandom_range(255));
		r.byte_valid        = 1'($urandom_range(1));
		r.first_of_fragment = 1'($urandom_range(1));
		r.end_flag          = 1'($urandom_range(1));
		r.broadcast_class   = 1'($urandom_range(1));
		r.message_id        = $urandom;
		r.source_addr       = 48'({$urandom, $urandom});
		r.dest_addr         = 48'({$urandom, $urandom});
		return r;
	endfunction

	function automatic frasm_pkg::req_t frag_req(input int frag, input int offs,
			input logic [7:0] data, input logic first, input logic valid, input logic endf,
			input logic bcast);
		frasm_pkg::req_t r;
		r.cmd               = frasm_pkg::CMD_FRAG;
		r.frag_number       = 8'(frag);
		r.byte_offset       = 8'(offs);
		r.data_byte         = data;
		r.byte_valid        = valid;
		r.first_of_fragment = first;
		r.end_flag          = endf;
		r.broadcast_class   = bcast;
		r.message_id        = cur_id;
		r.source_addr       = cur_src;
		r.dest_addr         = cur_dst;
		return r;
	endfunction

	function automatic frasm_pkg::req_t read_req(input int frag, input int offs);
		frasm_pkg::req_t r;
		r             = random_item();
		r.cmd         = frasm_pkg::CMD_READ;
		r.frag_number = 8'(frag);
		r.byte_offset = 8'(offs);
		return r;
	endfunction

	// Mirror of which buffer bytes hold data, so reads never hit unwritten entries.
	task automatic note_accepted(input frasm_pkg::req_t r);
		int addr;
		addr = int'(r.frag_number) * FRAG_SIZE + int'(r.byte_offset);
		case (r.cmd)
			frasm_pkg::CMD_FRAG: begin
				if (r.first_of_fragment) begin
					if (r.frag_number >= MAX_FRAGMENTS || frag_sent[r.frag_number]) begin
						skipping = 1'b1;
					end else begin
						skipping = 1'b0;
						frag_sent[r.frag_number] = 1'b1;
					end
				end
				if (r.frag_number < MAX_FRAGMENTS && !skipping && r.byte_valid &&
						r.byte_offset < FRAG_SIZE && !byte_written[addr]) begin
					byte_written[addr] = 1'b1;
					written_list.push_back(addr);
				end
			end
			frasm_pkg::CMD_CLEAR: begin
				foreach (frag_sent[i])
					frag_sent[i] = 1'b0;
				skipping = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic send_request(input frasm_pkg::req_t r, input logic last);
		int gap;
		gap = 0;
		while (gap < 60 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req       <= r;
		frag_last <= last;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		accepted_items++;
		note_accepted(r);
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [31:0] ticks);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= ticks;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic send_tick();
		frasm_pkg::req_t r;
		r     = random_item();
		r.cmd = frasm_pkg::CMD_TICK;
		send_request(r, 1'($urandom_range(1)));
	endtask

	task automatic send_clear();
		frasm_pkg::req_t r;
		r     = random_item();
		r.cmd = frasm_pkg::CMD_CLEAR;
		send_request(r, 1'($urandom_range(1)));
	endtask

	task automatic send_read();
		int addr;
		if (written_list.size() != 0 && $urandom_range(7) != 0) begin
			addr = written_list[$urandom_range(written_list.size() - 1)];
			send_request(read_req(addr / FRAG_SIZE, addr % FRAG_SIZE), 1'($urandom_range(1)));
		end else begin
			send_request(read_req($urandom_range(255, MAX_FRAGMENTS), $urandom_range(255)),
				1'($urandom_range(1)));
		end
	endtask

	task automatic new_header();
		cur_id  = $urandom;
		cur_src = 48'({$urandom, $urandom});
		cur_dst = 48'({$urandom, $urandom});
	endtask

	task automatic send_fragment(input int frag, input int nbytes, input logic endf,
			input logic bcast);
		int base;
		base = $urandom_range(255);
		if (nbytes == 0) begin
			send_request(frag_req(frag, base, 8'($urandom_range(255)), 1'b1, 1'b0, endf, bcast),
				1'b1);
		end else begin
			for (int i = 0; i < nbytes; i++) begin
				if (i != 0 && $urandom_range(9) == 0) begin
					if ($urandom_range(1) == 0)
						send_tick();
					else
						send_read();
				end
				send_request(frag_req(frag, (base + i) % 256, 8'($urandom_range(255)), i == 0,
					$urandom_range(7) != 0, endf, bcast), i == nbytes - 1);
			end
		end
	endtask

	task automatic send_message(input int max_frags);
		int   order [$];
		int   n;
		int   j;
		int   tmp;
		logic bcast;
		if ($urandom_range(7) != 0)
			send_clear();
		new_header();
		n     = $urandom_range(max_frags, 1);
		bcast = ($urandom_range(3) == 0);
		for (int i = 0; i < n; i++)
			order.push_back(i);
		for (int i = n - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			tmp      = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		if (n > 1 && $urandom_range(4) == 0)
			order.delete(0);
		if ($urandom_range(2) == 0)
			order.insert($urandom_range(order.size()), order[$urandom_range(order.size() - 1)]);
		if ($urandom_range(5) == 0)
			order.insert($urandom_range(order.size()), $urandom_range(255, MAX_FRAGMENTS));
		foreach (order[k]) begin
			if ($urandom_range(3) == 0)
				new_header();
			if ($urandom_range(4) == 0)
				send_tick();
			send_fragment(order[k], $urandom_range(5), order[k] == n - 1,
				bcast ^ ($urandom_range(7) == 0));
		end
		repeat ($urandom_range(6)) send_tick();
		repeat ($urandom_range(3)) send_read();
	endtask

	task automatic send_noise();
		frasm_pkg::req_t r;
		r = random_item();
		if (r.cmd == frasm_pkg::CMD_READ)
			send_read();
		else
			send_request(r, 1'($urandom_range(1)));
	endtask

	task automatic run_directed();
		send_request(read_req(255, 0), 1'b0);
		send_request(read_req(MAX_FRAGMENTS, 255), 1'b1);
		send_tick();
		cur_id  = '1;
		cur_src = '1;
		cur_dst = '1;
		send_request(frag_req(0, 0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0);
		send_request(frag_req(0, 255, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
		// same fragment again: dropped whole
		send_request(frag_req(0, 1, 8'h5A, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0);
		send_request(frag_req(0, 2, 8'hA5, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
		send_request(frag_req(255, 0, 8'h11, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0);
		send_request(frag_req(1, 3, 8'h22, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
		cur_id  = '0;
		cur_src = '0;
		cur_dst = '0;
		// empty end fragment completes the message
		send_request(frag_req(1, 0, 8'h33, 1'b1, 1'b0, 1'b1, 1'b0), 1'b1);
		send_request(frag_req(MAX_FRAGMENTS - 1, 255, 8'h80, 1'b1, 1'b1, 1'b0, 1'b1), 1'b1);
		send_tick();
		send_request(read_req(0, 0), 1'b0);
		send_request(read_req(0, 255), 1'b0);
		send_request(read_req(MAX_FRAGMENTS - 1, 255), 1'b0);
		send_clear();
		send_request(read_req(0, 255), 1'b0);
		write_timeout(32'd1);
		send_request(frag_req(3, 7, 8'h44, 1'b1, 1'b1, 1'b0, 1'b0), 1'b1);
		send_tick();
		send_tick();
	endtask

	initial begin
		int target;
		req       = '0;
		frag_last = 1'b0;
		req_valid = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		skipping  = 1'b0;
		cur_id    = '0;
		cur_src   = '0;
		cur_dst   = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
					write_timeout(32'd2);
				end
				1: begin
					tx_idle_pct  = 54;
					rx_stall_pct = 0;
					write_timeout(32'hFFFF_FFFF);
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 54;
					write_timeout(32'd1);
				end
				default: begin
					tx_idle_pct  = 26;
					rx_stall_pct = 26;
					write_timeout(32'($urandom_range(10, 3)));
				end
			endcase
			target = accepted_items + RANDOM_ITEMS / 4;
			while (accepted_items < target) begin
				if ($urandom_range(99) < 15)
					send_noise();
				else
					send_message(8);
			end
		end

		// back-to-back continuation bytes scattered over the buffer
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		write_timeout(frasm_pkg::TIMEOUT_RESET);
		send_clear();
		send_request(frag_req(9, 0, 8'h5A, 1'b1, 1'b1, 1'b0, 1'b1), 1'b0);
		repeat (LONG_STREAM)
			send_request(frag_req($urandom_range(MAX_FRAGMENTS - 1), $urandom_range(255),
				8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, 1'b0), 1'b0);
		repeat (4) send_read();
		send_tick();
		send_clear();

		drain();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
